// ===== hw/rtl/ocg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ocg_pkg
// Shared types and constants of the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package ocg_pkg;

    localparam int COORD_W   = 8;   // grid index width on the ports
    localparam int VALUE_W   = 7;   // stored cell value width
    localparam int SPAN_W    = 10;  // doubled absolute span
    localparam int ERR_W     = 12;  // Bresenham error, two's complement
    localparam int REG_IDX_W = 2;

    localparam logic ACT_TRACE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_FREE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OCCUPIED = 2'd1;

    localparam logic [VALUE_W-1:0] FREE_RESET     = 7'd10;
    localparam logic [VALUE_W-1:0] OCCUPIED_RESET = 7'd90;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic                 is_read;
        logic [COORD_W-1:0]   x0;       // sensor cell, or the cell to read
        logic [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]   x1;       // hit cell
        logic [COORD_W-1:0]   y1;
        logic                 x_major;
        logic [SPAN_W-1:0]    t_major;
        logic [SPAN_W-1:0]    t_minor;
        logic [ERR_W-1:0]     err0;
        logic                 x_neg;
        logic                 x_pos;
        logic                 y_neg;
        logic                 y_pos;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } queue_head_t;

endpackage
`default_nettype wire

// ===== hw/rtl/occupancy_grid_ray_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Square occupancy grid updated by Bresenham ray traces, with cell reads.
//
//   channel   handshake               payload
//   --------  ----------------------  ----------------------------------------
//   item in   start, busy             action, start_x/y, end_x/y, read_x/y
//   result    valid (1-cycle strobe)  cell_value
//   config    wr_en (no wait)         wr_index, wr_data
//
// A read passes the front register and the queue; the back end pops it in its
// idle state and shows the registered RAM data in its read state. A trace first
// writes its hit cell, then walks, one cell written per cycle on its single write
// port. Front and back are parted by a two-entry queue, so up to three items
// can be taken while a trace is walked.
// After reset all GRID_SIZE*GRID_SIZE cells are cleared; busy is high meanwhile.
// The result side cannot be stalled.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update
    import ocg_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 action,
    input  wire logic [COORD_W-1:0]   start_x,
    input  wire logic [COORD_W-1:0]   start_y,
    input  wire logic [COORD_W-1:0]   end_x,
    input  wire logic [COORD_W-1:0]   end_y,
    input  wire logic [COORD_W-1:0]   read_x,
    input  wire logic [COORD_W-1:0]   read_y,
    output logic                      valid,
    output logic      [VALUE_W-1:0]   cell_value,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [VALUE_W-1:0]   wr_data
);

    logic [VALUE_W-1:0] free_value_reg;
    logic [VALUE_W-1:0] free_value_next;
    logic [VALUE_W-1:0] occupied_value_reg;
    logic [VALUE_W-1:0] occupied_value_next;

    logic               front_ready;
    logic               clearing;
    logic               push;
    desc_t              push_desc;
    logic               full;
    logic               pop;
    queue_head_t        head;

    always_comb
    begin
        free_value_next     = free_value_reg;
        occupied_value_next = occupied_value_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_FREE:     free_value_next     = wr_data;
                REG_OCCUPIED: occupied_value_next = wr_data;
                default:      ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_value_reg     <= FREE_RESET;
            occupied_value_reg <= OCCUPIED_RESET;
        end
        else
        begin
            free_value_reg     <= free_value_next;
            occupied_value_reg <= occupied_value_next;
        end
    end

    assign busy = !front_ready;

    ocg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (clearing),
        .start     (start),
        .ready     (front_ready),
        .action    (action),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .read_x    (read_x),
        .read_y    (read_y),
        .full      (full),
        .push      (push),
        .push_desc (push_desc)
    );

    ocg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .head      (head)
    );

    ocg_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .free_value     (free_value_reg),
        .occupied_value (occupied_value_reg),
        .clearing       (clearing),
        .valid          (valid),
        .cell_value     (cell_value)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ocg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ocg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ocg_ram #(
    parameter int unsigned WIDTH = 7,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ocg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ocg_front
// Accepts items, works out span, direction and initial error of a trace,
// and hands the classified item on to the queue.
// ----------------------------------------------------------------------------
module ocg_front
    import ocg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               hold,
    input  wire logic               start,
    output logic                    ready,
    input  wire logic               action,
    input  wire logic [COORD_W-1:0] start_x,
    input  wire logic [COORD_W-1:0] start_y,
    input  wire logic [COORD_W-1:0] end_x,
    input  wire logic [COORD_W-1:0] end_y,
    input  wire logic [COORD_W-1:0] read_x,
    input  wire logic [COORD_W-1:0] read_y,
    input  wire logic               full,
    output logic                    push,
    output desc_t                   push_desc
);

    logic               valid_reg;
    logic               valid_next;
    desc_t              desc_reg;
    desc_t              desc_next;
    logic               accept;
    logic [COORD_W:0]   dx;
    logic [COORD_W:0]   dy;
    logic [COORD_W:0]   adx;
    logic [COORD_W:0]   ady;
    logic [SPAN_W-1:0]  tdx;
    logic [SPAN_W-1:0]  tdy;

    assign push   = valid_reg && !full;
    assign ready  = !hold && !(valid_reg && full);
    assign accept = start && ready;

    always_comb
    begin
        dx  = {1'b0, end_x} - {1'b0, start_x};
        dy  = {1'b0, end_y} - {1'b0, start_y};
        adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
        ady = dy[COORD_W] ? (~dy + 1'b1) : dy;
        tdx = SPAN_W'({adx, 1'b0});
        tdy = SPAN_W'({ady, 1'b0});

        desc_next.is_read = (action == ACT_READ);
        desc_next.x0      = desc_next.is_read ? read_x : start_x;
        desc_next.y0      = desc_next.is_read ? read_y : start_y;
        desc_next.x1      = end_x;
        desc_next.y1      = end_y;
        desc_next.x_major = (tdx >= tdy);
        desc_next.t_major = desc_next.x_major ? tdx : tdy;
        desc_next.t_minor = desc_next.x_major ? tdy : tdx;
        desc_next.err0    = ERR_W'(desc_next.t_minor) - ERR_W'(desc_next.t_major >> 1);
        desc_next.x_neg   = dx[COORD_W];
        desc_next.x_pos   = !dx[COORD_W] && (dx != '0);
        desc_next.y_neg   = dy[COORD_W];
        desc_next.y_pos   = !dy[COORD_W] && (dy != '0);

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

    assign push_desc = desc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ocg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ocg_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ocg_queue
    import ocg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output queue_head_t head
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ocg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ocg_back
// Owns the grid RAM: clears it after reset, answers reads, and walks each
// trace one cell per cycle.
// ----------------------------------------------------------------------------
module ocg_back
    import ocg_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire queue_head_t        head,
    output logic                    pop,
    input  wire logic [VALUE_W-1:0] free_value,
    input  wire logic [VALUE_W-1:0] occupied_value,
    output logic                    clearing,
    output logic                    valid,
    output logic      [VALUE_W-1:0] cell_value
);

    localparam int unsigned DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned PW    = AW + COORD_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WALK  = 2'd3;

    logic [1:0]         state_reg,    state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               oob_reg,      oob_next;
    logic [COORD_W-1:0] x_reg,        x_next;
    logic [COORD_W-1:0] y_reg,        y_next;
    logic [COORD_W-1:0] x1_reg,       x1_next;
    logic [COORD_W-1:0] y1_reg,       y1_next;
    logic [ERR_W-1:0]   err_reg,      err_next;
    logic [SPAN_W-1:0]  tmaj_reg,     tmaj_next;
    logic [SPAN_W-1:0]  tmin_reg,     tmin_next;
    logic               xmaj_reg,     xmaj_next;
    logic [3:0]         dirs_reg,     dirs_next;   // y_pos, y_neg, x_pos, x_neg

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;

    logic               maj_pos;
    logic               take_minor;
    logic [COORD_W-1:0] x_adv;
    logic [COORD_W-1:0] y_adv;
    logic               walk_done;

    function automatic logic in_grid(input logic [COORD_W-1:0] cx,
                                     input logic [COORD_W-1:0] cy);
        return (32'(cx) < GRID_SIZE) && (32'(cy) < GRID_SIZE);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy);
        logic [PW-1:0] p;
        p = PW'(cx) * PW'(GRID_SIZE) + PW'(cy);
        return p[AW-1:0];
    endfunction

    ocg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // One Bresenham step from the current cell.
    always_comb
    begin
        maj_pos    = xmaj_reg ? dirs_reg[1] : dirs_reg[3];
        take_minor = !err_reg[ERR_W-1] && ((err_reg != '0) || maj_pos);
        x_adv      = dirs_reg[0] ? (x_reg - 1'b1) : (dirs_reg[1] ? (x_reg + 1'b1) : x_reg);
        y_adv      = dirs_reg[2] ? (y_reg - 1'b1) : (dirs_reg[3] ? (y_reg + 1'b1) : y_reg);
        walk_done  = xmaj_reg ? (x_adv == x1_reg) : (y_adv == y1_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        oob_next      = oob_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        err_next      = err_reg;
        tmaj_next     = tmaj_reg;
        tmin_next     = tmin_reg;
        xmaj_next     = xmaj_reg;
        dirs_next     = dirs_reg;
        pop           = 1'b0;
        we            = 1'b0;
        waddr         = clr_addr_reg;
        wdata         = '0;
        raddr         = cell_addr(head.desc.x0, head.desc.y0);

        unique case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.desc.is_read)
                    begin
                        oob_next   = !in_grid(head.desc.x0, head.desc.y0);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // hit cell first, then the walk
                        we        = in_grid(head.desc.x1, head.desc.y1);
                        waddr     = cell_addr(head.desc.x1, head.desc.y1);
                        wdata     = occupied_value;
                        x_next    = head.desc.x0;
                        y_next    = head.desc.y0;
                        x1_next   = head.desc.x1;
                        y1_next   = head.desc.y1;
                        err_next  = head.desc.err0;
                        tmaj_next = head.desc.t_major;
                        tmin_next = head.desc.t_minor;
                        xmaj_next = head.desc.x_major;
                        dirs_next = {head.desc.y_pos, head.desc.y_neg,
                                     head.desc.x_pos, head.desc.x_neg};
                        if (head.desc.t_major != '0)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                we       = in_grid(x_reg, y_reg);
                waddr    = cell_addr(x_reg, y_reg);
                wdata    = free_value;
                err_next = err_reg + ERR_W'(tmin_reg)
                           - (take_minor ? ERR_W'(tmaj_reg) : '0);
                if (xmaj_reg)
                begin
                    x_next = x_adv;
                    y_next = take_minor ? y_adv : y_reg;
                end
                else
                begin
                    y_next = y_adv;
                    x_next = take_minor ? x_adv : x_reg;
                end
                if (walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oob_reg  <= oob_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        err_reg  <= err_next;
        tmaj_reg <= tmaj_next;
        tmin_reg <= tmin_next;
        xmaj_reg <= xmaj_next;
        dirs_reg <= dirs_next;
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign valid      = (state_reg == ST_READ);
    assign cell_value = oob_reg ? '0 : rdata;

endmodule
`default_nettype wire

// ===== tb/sv/occupancy_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_checker
// Watches the item, result and register channels of the ray update block.
// Keeps a shadow copy of the grid and walks each accepted ray into it, queues
// the value due for each accepted read, and compares every result strobe
// against the oldest value due. Failures are counted and handed upward.
// ----------------------------------------------------------------------------
module occupancy_grid_checker
    import ocg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 action,
    input  wire logic [COORD_W-1:0]   start_x,
    input  wire logic [COORD_W-1:0]   start_y,
    input  wire logic [COORD_W-1:0]   end_x,
    input  wire logic [COORD_W-1:0]   end_y,
    input  wire logic [COORD_W-1:0]   read_x,
    input  wire logic [COORD_W-1:0]   read_y,
    input  wire logic                 valid,
    input  wire logic [VALUE_W-1:0]   cell_value,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [VALUE_W-1:0]   wr_data,
    output int                        fail_count,
    output int                        reads_outstanding,
    output int                        reads_checked
);

    localparam int GRID_SIZE = 256;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VALUE_W-1:0] value;
    } cell_due_t;

    logic [VALUE_W-1:0] grid_shadow [0:GRID_SIZE*GRID_SIZE-1];
    logic [VALUE_W-1:0] free_level;
    logic [VALUE_W-1:0] occupied_level;
    cell_due_t          cells_due [$];
    cell_due_t          oldest;
    cell_due_t          fresh;

    // Walk one ray into the shadow grid: hit cell occupied, earlier cells free.
    task automatic mark_ray(input int x0, input int y0, input int x1, input int y1);
        int dx;
        int dy;
        int sx;
        int sy;
        int tdx;
        int tdy;
        int x;
        int y;
        int slope_err;
        dx  = x1 - x0;
        dy  = y1 - y0;
        sx  = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        sy  = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        tdx = ((dx < 0) ? -dx : dx) * 2;
        tdy = ((dy < 0) ? -dy : dy) * 2;
        x   = x0;
        y   = y0;
        grid_shadow[x1 * GRID_SIZE + y1] = occupied_level;
        if (tdx >= tdy)
        begin
            slope_err = tdy - tdx / 2;
            while (x != x1)
            begin
                grid_shadow[x * GRID_SIZE + y] = free_level;
                // on a tie, step the minor axis only when moving forward
                if (slope_err > 0 || (slope_err == 0 && sx > 0))
                begin
                    slope_err -= tdx;
                    y += sy;
                end
                slope_err += tdy;
                x += sx;
            end
        end
        else
        begin
            slope_err = tdx - tdy / 2;
            while (y != y1)
            begin
                grid_shadow[x * GRID_SIZE + y] = free_level;
                if (slope_err > 0 || (slope_err == 0 && sy > 0))
                begin
                    slope_err -= tdy;
                    x += sx;
                end
                slope_err += tdx;
                y += sy;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_SIZE * GRID_SIZE; i++)
                grid_shadow[i] = '0;
            free_level        = FREE_RESET;
            occupied_level    = OCCUPIED_RESET;
            cells_due.delete();
            fail_count        = 0;
            reads_outstanding = 0;
            reads_checked     = 0;
        end
        else
        begin
            if (valid)
            begin
                if (cells_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: cell_value %0d arrived with no read waiting",
                             $time, cell_value);
                end
                else
                begin
                    oldest = cells_due.pop_front();
                    reads_checked++;
                    if (cell_value !== oldest.value)
                    begin
                        fail_count++;
                        $display("%0t: read (%0d,%0d) cell_value expected %0d, got %0d",
                                 $time, oldest.x, oldest.y, oldest.value, cell_value);
                    end
                end
            end

            if (wr_en)
            begin
                case (wr_index)
                    REG_FREE:     free_level     = wr_data;
                    REG_OCCUPIED: occupied_level = wr_data;
                    default:      ;  // drop writes past the register list
                endcase
            end

            if (start && !busy)
            begin
                if (action == ACT_READ)
                begin
                    fresh.x     = read_x;
                    fresh.y     = read_y;
                    fresh.value = grid_shadow[int'(read_x) * GRID_SIZE + int'(read_y)];
                    cells_due   = {cells_due, fresh};
                end
                else
                begin
                    mark_ray(int'(start_x), int'(start_y), int'(end_x), int'(end_y));
                end
            end

            reads_outstanding = cells_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_occupancy_grid_ray_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_ray_update
// Drives rays and cell reads into the occupancy grid block in random bursts,
// with directed rays first (grid corners, diagonals, a single cell, straight
// lines, tie steps in both directions), then random phases under several
// free/occupied settings. Reads mostly land on or near recent rays.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_ray_update;
    import ocg_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // past the register list
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 1000;  // covers a full queue of longest rays
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 386;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic [COORD_W-1:0]   read_x;
    logic [COORD_W-1:0]   read_y;
    logic                 valid;
    logic [VALUE_W-1:0]   cell_value;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [VALUE_W-1:0]   wr_data;

    int fail_count;
    int reads_outstanding;
    int reads_checked;
    int cycles = 0;
    int traces_sent = 0;
    int reads_sent = 0;
    int settings_used = 1;
    int burst_left = 0;

    logic [COORD_W-1:0] ray_x0;
    logic [COORD_W-1:0] ray_y0;
    logic [COORD_W-1:0] ray_x1;
    logic [COORD_W-1:0] ray_y1;
    logic [VALUE_W-1:0] free_pick;
    logic [VALUE_W-1:0] occupied_pick;

    occupancy_grid_ray_update uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .read_x     (read_x),
        .read_y     (read_y),
        .valid      (valid),
        .cell_value (cell_value),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    occupancy_grid_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .start_x           (start_x),
        .start_y           (start_y),
        .end_x             (end_x),
        .end_y             (end_y),
        .read_x            (read_x),
        .read_y            (read_y),
        .valid             (valid),
        .cell_value        (cell_value),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .fail_count        (fail_count),
        .reads_outstanding (reads_outstanding),
        .reads_checked     (reads_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // Hold the item until a rising edge finds busy low.
    task automatic send_item(input logic act,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry);
        @(negedge clk);
        start   <= 1'b1;
        action  <= act;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        read_x  <= rx;
        read_y  <= ry;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_READ)
            reads_sent++;
        else
            traces_sent++;
    endtask

    task automatic send_trace(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        ray_x0 = sx;
        ray_y0 = sy;
        ray_x1 = ex;
        ray_y1 = ey;
        send_item(ACT_TRACE, sx, sy, ex, ey, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        send_item(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), x, y);
    endtask

    task automatic idle_for(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Drop start, wait out every read and any ray still being walked.
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (reads_outstanding != 0 || busy)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c, input int reach);
        int v;
        v = int'(c) + $urandom_range(0, 2 * reach) - reach;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COORD_W'(v);
    endfunction

    task automatic random_item();
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        sx = 8'($urandom_range(0, 255));
        sy = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 45)
        begin
            case ($urandom_range(0, 4))
                0: send_read(ray_x1, ray_y1);
                1: send_read(ray_x0, ray_y0);
                2: send_read(8'((int'(ray_x0) + int'(ray_x1)) / 2),
                             8'((int'(ray_y0) + int'(ray_y1)) / 2));
                3: send_read(nudge(ray_x1, 1), nudge(ray_y1, 1));
                default: send_read(sx, sy);
            endcase
        end
        else if ($urandom_range(0, 99) < 85)
            send_trace(sx, sy, nudge(sx, 12), nudge(sy, 12));
        else
            send_trace(sx, sy, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = ACT_TRACE;
        start_x  = '0;
        start_y  = '0;
        end_x    = '0;
        end_y    = '0;
        read_x   = '0;
        read_y   = '0;
        wr_en    = 1'b0;
        wr_index = REG_FREE;
        wr_data  = '0;
        ray_x0   = '0;
        ray_y0   = '0;
        ray_x1   = '0;
        ray_y1   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait out the clearing pass, then poke an unused index
        drain_block();
        write_reg(REG_SPARE, 7'd55);

        // directed rays under reset register values
        send_trace(8'd0, 8'd0, 8'd255, 8'd255);
        send_read(8'd255, 8'd255);
        send_read(8'd0, 8'd0);
        send_read(8'd128, 8'd128);
        send_trace(8'd255, 8'd0, 8'd0, 8'd255);
        send_read(8'd0, 8'd255);
        send_read(8'd255, 8'd0);
        send_trace(8'd10, 8'd20, 8'd10, 8'd20);
        send_read(8'd10, 8'd20);
        // tie on the first step, x-major, moving backward: no minor step
        send_trace(8'd2, 8'd0, 8'd0, 8'd1);
        send_read(8'd1, 8'd0);
        send_read(8'd1, 8'd1);
        // tie, x-major, moving forward: minor step taken
        send_trace(8'd40, 8'd50, 8'd42, 8'd51);
        send_read(8'd41, 8'd51);
        send_read(8'd41, 8'd50);
        // tie, y-major, moving backward
        send_trace(8'd60, 8'd62, 8'd61, 8'd60);
        send_read(8'd60, 8'd61);
        send_read(8'd61, 8'd61);
        send_trace(8'd0, 8'd100, 8'd255, 8'd100);
        send_trace(8'd200, 8'd255, 8'd200, 8'd0);
        send_read(8'd200, 8'd100);
        send_read(8'd200, 8'd255);
        send_read(8'd0, 8'd100);
        drain_block();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin free_pick = 7'd0;   occupied_pick = 7'd100; end
                1: begin free_pick = 7'd100; occupied_pick = 7'd0;   end
                2: begin free_pick = 7'd127; occupied_pick = 7'd127; end
                default:
                begin
                    free_pick     = 7'($urandom_range(0, 127));
                    occupied_pick = 7'($urandom_range(0, 127));
                end
            endcase
            write_reg(REG_FREE, free_pick);
            write_reg(REG_OCCUPIED, occupied_pick);
            settings_used++;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    // some long bursts with no gap, most short with a gap
                    if ($urandom_range(0, 3) == 0)
                        burst_left = $urandom_range(20, 60);
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        idle_for($urandom_range(1, 10));
                    end
                end
                burst_left--;
                random_item();
            end
            drain_block();
        end

        $display("sent %0d rays and %0d cell reads, %0d read results checked",
                 traces_sent, reads_sent, reads_checked);
        $display("%0d free/occupied settings used, 0, 100 and 127 among them",
                 settings_used);
        if (fail_count == 0 && reads_outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ocg_pkg.sv
hw/rtl/ocg_ram.sv
hw/rtl/ocg_front.sv
hw/rtl/ocg_queue.sv
hw/rtl/ocg_back.sv
hw/rtl/occupancy_grid_ray_update.sv
tb/sv/occupancy_grid_checker.sv
tb/sv/tb_occupancy_grid_ray_update.sv
